FILE: hw/rtl/lqa_pkg.sv
`default_nettype none

package lqa_pkg;

  // fraction bits of the unit vectors and of the quaternion
  localparam int QFB = 30;
  // cells in one square root chain and in one divider chain
  localparam int NCELL = 32;

  // conversion branch codes
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  // input beat
  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
  } lqa_in_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               degenerate;
  } lqa_out_t;

  // data that rides along with a vector through the normalizer
  typedef struct packed {
    logic             dg;
    logic [2:0][31:0] f;
  } lqa_side_t;

  // payload carried by the arithmetic cells
  typedef struct packed {
    lqa_side_t        side;
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][29:0] mag;
    logic [1:0]       br;
    logic [2:0][35:0] num;
    logic [31:0]      prin;
    logic [2:0]       ovf;
  } lqa_pay_t;

  // square root cell state
  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
  } lqa_sqst_t;

  // three-lane divider cell state, one shared divisor
  typedef struct packed {
    logic [32:0]       den;
    logic [2:0][32:0]  rem;
    logic [2:0][31:0]  nlo;
    logic [2:0][31:0]  q;
  } lqa_dvst_t;

  // index of the highest set bit, zero for zero
  function automatic logic [5:0] lqa_msb(input logic [32:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 33; i++) begin
      if (x[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lqa_sqrt_cell.sv
`default_nettype none

module lqa_sqrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  lqa_pkg::lqa_sqst_t  st_i,
  input  lqa_pkg::lqa_pay_t   pay_i,
  output logic                vld_o,
  output lqa_pkg::lqa_sqst_t  st_o,
  output lqa_pkg::lqa_pay_t   pay_o
);
  import lqa_pkg::*;

  logic      vld_q;
  lqa_sqst_t st_d, st_q;
  lqa_pay_t  pay_q;
  logic [63:0] trial;

  // one result bit of the integer square root
  always_comb begin
    trial = st_i.res + st_i.bt;
    st_d.bt = st_i.bt >> 2;
    if (st_i.v >= trial) begin
      st_d.v   = st_i.v - trial;
      st_d.res = (st_i.res >> 1) + st_i.bt;
    end else begin
      st_d.v   = st_i.v;
      st_d.res = st_i.res >> 1;
    end
  end

  // valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // data
  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    pay_q <= pay_i;
  end

  assign vld_o = vld_q;
  assign st_o  = st_q;
  assign pay_o = pay_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lqa_div_cell.sv
`default_nettype none

module lqa_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  lqa_pkg::lqa_dvst_t  st_i,
  input  lqa_pkg::lqa_pay_t   pay_i,
  output logic                vld_o,
  output lqa_pkg::lqa_dvst_t  st_o,
  output lqa_pkg::lqa_pay_t   pay_o
);
  import lqa_pkg::*;

  logic      vld_q;
  lqa_dvst_t st_d, st_q;
  lqa_pay_t  pay_q;
  logic [33:0] part;
  logic        ge;

  // one quotient bit per lane, restoring
  always_comb begin
    st_d.den = st_i.den;
    part = '0;
    ge   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      part = {st_i.rem[i], st_i.nlo[i][31]};
      ge   = part >= {1'b0, st_i.den};
      st_d.rem[i] = ge ? 33'(part - {1'b0, st_i.den}) : part[32:0];
      st_d.nlo[i] = {st_i.nlo[i][30:0], 1'b0};
      st_d.q[i]   = {st_i.q[i][30:0], ge};
    end
  end

  // valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // data
  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    pay_q <= pay_i;
  end

  assign vld_o = vld_q;
  assign st_o  = st_q;
  assign pay_o = pay_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lqa_norm.sv
`default_nettype none

module lqa_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic [2:0][32:0]   vec_i,
  input  lqa_pkg::lqa_side_t side_i,
  output logic               vld_o,
  output logic [2:0][31:0]   unit_o,
  output logic               ok_o,
  output lqa_pkg::lqa_side_t side_o
);
  import lqa_pkg::*;

  // magnitudes, largest one and its top bit
  logic [2:0][32:0] mag_c;
  logic [32:0]      mx_c;

  always_comb begin
    mx_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec_i[i][32] ? 33'(~vec_i[i] + 33'd1) : vec_i[i];
      if (mag_c[i] > mx_c) begin
        mx_c = mag_c[i];
      end
    end
  end

  logic             s1_vld_q;
  logic [2:0][32:0] s1_mag_q;
  logic [2:0]       s1_neg_q;
  logic             s1_zero_q;
  logic [5:0]       s1_msb_q;
  lqa_side_t        s1_side_q;

  // common shift that puts the largest magnitude in [2^29, 2^30)
  logic [5:0]       shr, shl;
  logic [32:0]      tmp_r, tmp_l;
  logic [2:0][29:0] sh_c;

  always_comb begin
    shr = (s1_msb_q > 6'd29) ? 6'(s1_msb_q - 6'd29) : 6'd0;
    shl = (s1_msb_q < 6'd29) ? 6'(6'd29 - s1_msb_q) : 6'd0;
    tmp_r = '0;
    tmp_l = '0;
    for (int i = 0; i < 3; i++) begin
      tmp_r = s1_mag_q[i] >> shr;
      tmp_l = tmp_r << shl;
      sh_c[i] = tmp_l[29:0];
    end
  end

  logic             s2_vld_q;
  logic [2:0][29:0] s2_mag_q;
  logic [2:0]       s2_neg_q;
  logic             s2_zero_q;
  lqa_side_t        s2_side_q;

  logic             s3_vld_q;
  logic [2:0][59:0] s3_sqr_q;
  logic [2:0][29:0] s3_mag_q;
  logic [2:0]       s3_neg_q;
  logic             s3_zero_q;
  lqa_side_t        s3_side_q;

  logic             s4_vld_q;
  logic [61:0]      s4_sum_q;
  logic [2:0][29:0] s4_mag_q;
  logic [2:0]       s4_neg_q;
  logic             s4_zero_q;
  lqa_side_t        s4_side_q;

  // front stages: magnitude, shift, squares, sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mag_q  <= mag_c;
    s1_neg_q  <= {vec_i[2][32], vec_i[1][32], vec_i[0][32]};
    s1_zero_q <= (mx_c == '0);
    s1_msb_q  <= lqa_msb(mx_c);
    s1_side_q <= side_i;

    s2_mag_q  <= sh_c;
    s2_neg_q  <= s1_neg_q;
    s2_zero_q <= s1_zero_q;
    s2_side_q <= s1_side_q;

    for (int i = 0; i < 3; i++) begin
      s3_sqr_q[i] <= 60'(s2_mag_q[i]) * 60'(s2_mag_q[i]);
    end
    s3_mag_q  <= s2_mag_q;
    s3_neg_q  <= s2_neg_q;
    s3_zero_q <= s2_zero_q;
    s3_side_q <= s2_side_q;

    s4_sum_q  <= 62'(s3_sqr_q[0]) + 62'(s3_sqr_q[1]) + 62'(s3_sqr_q[2]);
    s4_mag_q  <= s3_mag_q;
    s4_neg_q  <= s3_neg_q;
    s4_zero_q <= s3_zero_q;
    s4_side_q <= s3_side_q;
  end

  // square root chain for the length
  logic      sq_vld [NCELL+1];
  lqa_sqst_t sq_st  [NCELL+1];
  lqa_pay_t  sq_pay [NCELL+1];

  always_comb begin
    sq_vld[0]       = s4_vld_q;
    sq_st[0].v      = {2'b00, s4_sum_q};
    sq_st[0].res    = '0;
    sq_st[0].bt     = 64'd1 << 62;
    sq_pay[0]       = '0;
    sq_pay[0].side  = s4_side_q;
    sq_pay[0].neg   = s4_neg_q;
    sq_pay[0].zero  = s4_zero_q;
    sq_pay[0].mag   = s4_mag_q;
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_sq
    lqa_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (sq_vld[g]),
      .st_i   (sq_st[g]),
      .pay_i  (sq_pay[g]),
      .vld_o  (sq_vld[g+1]),
      .st_o   (sq_st[g+1]),
      .pay_o  (sq_pay[g+1])
    );
  end

  // dividend and divisor for the three components
  logic [32:0]  len_c;
  logic [63:0]  num_c;
  lqa_dvst_t    dv_init_c;

  always_comb begin
    len_c = sq_st[NCELL].res[32:0];
    dv_init_c.den = len_c;
    num_c = '0;
    for (int i = 0; i < 3; i++) begin
      num_c = (64'(sq_pay[NCELL].mag[i]) << QFB) + 64'(len_c >> 1);
      dv_init_c.rem[i] = {1'b0, num_c[63:32]};
      dv_init_c.nlo[i] = num_c[31:0];
      dv_init_c.q[i]   = '0;
    end
  end

  logic      s5_vld_q;
  lqa_dvst_t s5_st_q;
  lqa_pay_t  s5_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= sq_vld[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    s5_st_q  <= dv_init_c;
    s5_pay_q <= sq_pay[NCELL];
  end

  // divider chain
  logic      dv_vld [NCELL+1];
  lqa_dvst_t dv_st  [NCELL+1];
  lqa_pay_t  dv_pay [NCELL+1];

  assign dv_vld[0] = s5_vld_q;
  assign dv_st[0]  = s5_st_q;
  assign dv_pay[0] = s5_pay_q;

  for (genvar g = 0; g < NCELL; g++) begin : g_dv
    lqa_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (dv_vld[g]),
      .st_i   (dv_st[g]),
      .pay_i  (dv_pay[g]),
      .vld_o  (dv_vld[g+1]),
      .st_o   (dv_st[g+1]),
      .pay_o  (dv_pay[g+1])
    );
  end

  // restore signs
  logic             s6_vld_q;
  logic [2:0][31:0] s6_unit_q;
  logic             s6_ok_q;
  lqa_side_t        s6_side_q;
  logic [2:0][31:0] unit_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_c[i] = dv_pay[NCELL].neg[i] ? 32'(-dv_st[NCELL].q[i]) : dv_st[NCELL].q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= dv_vld[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    s6_unit_q <= unit_c;
    s6_ok_q   <= ~dv_pay[NCELL].zero;
    s6_side_q <= dv_pay[NCELL].side;
  end

  assign vld_o  = s6_vld_q;
  assign unit_o = s6_unit_q;
  assign ok_o   = s6_ok_q;
  assign side_o = s6_side_q;

endmodule

`default_nettype wire

FILE: hw/rtl/look_at_quaternion_unit.sv
`default_nettype none

// Look-at orientation to quaternion, fully pipelined.
// Input beat: eye and target positions, signed Q16.16, on in_i. A beat is taken
// at a clock edge with start high; busy stays low, so a new beat may follow in
// every cycle and up to about 210 beats are in flight at once.
// Result beat: quaternion w, x, y, z in signed Q2.30 plus the degenerate flag
// on res_o, shown for exactly one cycle with valid_o high. The receiver cannot
// hold results off; each one is taken at the edge that ends its cycle.
// A beat passes the input difference register, two vector normalizers (each of
// four front stages, 32 square root cells, one setup stage, 32 divider cells and
// a sign stage), three stages for the cross product and branch choice, the
// 32-cell square root of the conversion, one setup stage, 32 divider cells and
// the output register before valid_o rises. Throughput is one beat per cycle.
// Reset clears every valid flag in the pipeline, so beats in flight are
// dropped and no result appears until a new beat has gone all the way through.
// A zero-length forward or right vector gives an all-zero quaternion with the
// degenerate flag set.
module look_at_quaternion_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lqa_pkg::lqa_in_t  in_i,
  output logic              valid_o,
  output lqa_pkg::lqa_out_t res_o
);
  import lqa_pkg::*;

  localparam logic signed [64:0] RndHalf = 65'sd1 <<< (QFB - 1);
  localparam logic signed [35:0] OneQ    = 36'sd1 <<< QFB;

  // never stalls
  assign busy = 1'b0;

  // differences on the input beat
  logic                    in_vld_q;
  logic [2:0][32:0]        dif_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    dif_q[0] <= 33'(in_i.eye_x) - 33'(in_i.aim_x);
    dif_q[1] <= 33'(in_i.aim_y) - 33'(in_i.eye_y);
    dif_q[2] <= 33'(in_i.aim_z) - 33'(in_i.eye_z);
  end

  // forward vector
  logic             n1_vld;
  logic [2:0][31:0] fwd;
  logic             n1_ok;

  lqa_norm u_norm_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_vld_q),
    .vec_i  (dif_q),
    .side_i ('0),
    .vld_o  (n1_vld),
    .unit_o (fwd),
    .ok_o   (n1_ok),
    .side_o ()
  );

  // right vector from up x forward
  logic [2:0][32:0] rvec_c;
  lqa_side_t        n2_side_in;
  logic             n2_vld;
  logic [2:0][31:0] rgt;
  logic             n2_ok;
  lqa_side_t        n2_side;

  always_comb begin
    rvec_c[0]     = 33'($signed(fwd[2]));
    rvec_c[1]     = '0;
    rvec_c[2]     = 33'(-33'($signed(fwd[0])));
    n2_side_in.dg = ~n1_ok;
    n2_side_in.f  = fwd;
  end

  lqa_norm u_norm_rgt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (n1_vld),
    .vec_i  (rvec_c),
    .side_i (n2_side_in),
    .vld_o  (n2_vld),
    .unit_o (rgt),
    .ok_o   (n2_ok),
    .side_o (n2_side)
  );

  // products for the new up vector
  logic signed [31:0] f0, f1, f2, r0, r2;
  assign f0 = $signed(n2_side.f[0]);
  assign f1 = $signed(n2_side.f[1]);
  assign f2 = $signed(n2_side.f[2]);
  assign r0 = $signed(rgt[0]);
  assign r2 = $signed(rgt[2]);

  logic               a_vld_q, a_dg_q;
  logic signed [63:0] a_p1_q, a_p2_q, a_p3_q, a_p4_q;
  logic signed [31:0] a_f0_q, a_f1_q, a_f2_q, a_r0_q, a_r2_q;

  logic               b_vld_q, b_dg_q;
  logic signed [34:0] b_nu0_q, b_nu1_q, b_nu2_q;
  logic signed [31:0] b_f0_q, b_f1_q, b_f2_q, b_r0_q, b_r2_q;
  logic signed [64:0] nu0_w, nu1_w, nu2_w;

  always_comb begin
    nu0_w = (65'(a_p1_q) + RndHalf) >>> QFB;
    nu1_w = (65'(a_p2_q) - 65'(a_p3_q) + RndHalf) >>> QFB;
    nu2_w = (RndHalf - 65'(a_p4_q)) >>> QFB;
  end

  // matrix, trace and branch
  logic signed [35:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, tr;
  logic signed [35:0] rad_s, n0_c, n1_c, n2_c;
  logic [1:0]         br_c;

  always_comb begin
    m00 = 36'(b_r0_q);
    m01 = '0;
    m02 = 36'(b_r2_q);
    m10 = 36'(b_nu0_q);
    m11 = 36'(b_nu1_q);
    m12 = 36'(b_nu2_q);
    m20 = 36'(b_f0_q);
    m21 = 36'(b_f1_q);
    m22 = 36'(b_f2_q);
    tr  = m00 + m11 + m22;
    priority if (tr > 0) begin
      br_c = BR_TRACE;
    end else if (m00 > m11 && m00 > m22) begin
      br_c = BR_X;
    end else if (m11 > m22) begin
      br_c = BR_Y;
    end else begin
      br_c = BR_Z;
    end
    unique case (br_c)
      BR_TRACE: begin
        rad_s = tr + OneQ;
        n0_c  = m21 - m12;
        n1_c  = m02 - m20;
        n2_c  = m10 - m01;
      end
      BR_X: begin
        rad_s = OneQ + m00 - m11 - m22;
        n0_c  = m21 - m12;
        n1_c  = m01 + m10;
        n2_c  = m02 + m20;
      end
      BR_Y: begin
        rad_s = OneQ + m11 - m00 - m22;
        n0_c  = m02 - m20;
        n1_c  = m01 + m10;
        n2_c  = m12 + m21;
      end
      BR_Z: begin
        rad_s = OneQ + m22 - m00 - m11;
        n0_c  = m10 - m01;
        n1_c  = m02 + m20;
        n2_c  = m12 + m21;
      end
    endcase
  end

  logic             c_vld_q, c_dg_q;
  logic [34:0]      c_rad_q;
  logic [2:0][35:0] c_num_q;
  logic [1:0]       c_br_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= n2_vld;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_p1_q <= 64'(f1) * 64'(r2);
    a_p2_q <= 64'(f2) * 64'(r0);
    a_p3_q <= 64'(f0) * 64'(r2);
    a_p4_q <= 64'(f1) * 64'(r0);
    a_f0_q <= f0;
    a_f1_q <= f1;
    a_f2_q <= f2;
    a_r0_q <= r0;
    a_r2_q <= r2;
    a_dg_q <= n2_side.dg | ~n2_ok;

    b_nu0_q <= 35'(nu0_w);
    b_nu1_q <= 35'(nu1_w);
    b_nu2_q <= 35'(nu2_w);
    b_f0_q  <= a_f0_q;
    b_f1_q  <= a_f1_q;
    b_f2_q  <= a_f2_q;
    b_r0_q  <= a_r0_q;
    b_r2_q  <= a_r2_q;
    b_dg_q  <= a_dg_q;

    c_rad_q    <= rad_s[35] ? '0 : rad_s[34:0];
    c_num_q[0] <= n0_c;
    c_num_q[1] <= n1_c;
    c_num_q[2] <= n2_c;
    c_br_q     <= br_c;
    c_dg_q     <= b_dg_q;
  end

  // square root of the chosen radicand
  logic      sq_vld [NCELL+1];
  lqa_sqst_t sq_st  [NCELL+1];
  lqa_pay_t  sq_pay [NCELL+1];

  always_comb begin
    sq_vld[0]         = c_vld_q;
    sq_st[0].v        = 64'(c_rad_q) << QFB;
    sq_st[0].res      = '0;
    sq_st[0].bt       = 64'd1 << 62;
    sq_pay[0]         = '0;
    sq_pay[0].side.dg = c_dg_q;
    sq_pay[0].br      = c_br_q;
    sq_pay[0].num     = c_num_q;
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_sq
    lqa_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (sq_vld[g]),
      .st_i   (sq_st[g]),
      .pay_i  (sq_pay[g]),
      .vld_o  (sq_vld[g+1]),
      .st_o   (sq_st[g+1]),
      .pay_o  (sq_pay[g+1])
    );
  end

  // divisor, principal component, dividends and overflow
  logic [32:0]        sq_c, s_c;
  logic [33:0]        prin_w;
  logic signed [35:0] nm;
  logic [35:0]        nmag;
  logic [63:0]        dvd;
  lqa_dvst_t          e_init_c;
  lqa_pay_t           e_pay_c;

  always_comb begin
    sq_c   = sq_st[NCELL].res[32:0];
    s_c    = (sq_c == '0) ? 33'd1 : {sq_c[31:0], 1'b0};
    prin_w = (34'(sq_c) + 34'd1) >> 1;
    e_pay_c      = '0;
    e_pay_c.side = sq_pay[NCELL].side;
    e_pay_c.br   = sq_pay[NCELL].br;
    e_pay_c.prin = prin_w[31:0];
    e_init_c.den = s_c;
    nm   = '0;
    nmag = '0;
    dvd  = '0;
    for (int i = 0; i < 3; i++) begin
      nm   = $signed(sq_pay[NCELL].num[i]);
      nmag = nm[35] ? 36'(-nm) : 36'(nm);
      dvd  = (64'(nmag) << QFB) + 64'(s_c >> 1);
      e_pay_c.neg[i] = nm[35];
      e_pay_c.ovf[i] = {1'b0, dvd[63:32]} >= s_c;
      e_init_c.rem[i] = e_pay_c.ovf[i] ? '0 : {1'b0, dvd[63:32]};
      e_init_c.nlo[i] = dvd[31:0];
      e_init_c.q[i]   = '0;
    end
  end

  logic      e_vld_q;
  lqa_dvst_t e_st_q;
  lqa_pay_t  e_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= sq_vld[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    e_st_q  <= e_init_c;
    e_pay_q <= e_pay_c;
  end

  // divider chain for the three other components
  logic      dv_vld [NCELL+1];
  lqa_dvst_t dv_st  [NCELL+1];
  lqa_pay_t  dv_pay [NCELL+1];

  assign dv_vld[0] = e_vld_q;
  assign dv_st[0]  = e_st_q;
  assign dv_pay[0] = e_pay_q;

  for (genvar g = 0; g < NCELL; g++) begin : g_dv
    lqa_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (dv_vld[g]),
      .st_i   (dv_st[g]),
      .pay_i  (dv_pay[g]),
      .vld_o  (dv_vld[g+1]),
      .st_o   (dv_st[g+1]),
      .pay_o  (dv_pay[g+1])
    );
  end

  // saturate, sign and place the components
  logic [2:0][31:0] lane;
  logic [31:0]      qv;
  lqa_pay_t         fp;
  lqa_out_t         res_d;

  always_comb begin
    fp = dv_pay[NCELL];
    qv = '0;
    for (int i = 0; i < 3; i++) begin
      qv = dv_st[NCELL].q[i];
      if (fp.ovf[i] | qv[31]) begin
        lane[i] = fp.neg[i] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        lane[i] = fp.neg[i] ? 32'(-qv) : qv;
      end
    end
    res_d.degenerate = 1'b0;
    unique case (fp.br)
      BR_TRACE: begin
        res_d.quat_w = fp.prin;
        res_d.quat_x = lane[0];
        res_d.quat_y = lane[1];
        res_d.quat_z = lane[2];
      end
      BR_X: begin
        res_d.quat_w = lane[0];
        res_d.quat_x = fp.prin;
        res_d.quat_y = lane[1];
        res_d.quat_z = lane[2];
      end
      BR_Y: begin
        res_d.quat_w = lane[0];
        res_d.quat_x = lane[1];
        res_d.quat_y = fp.prin;
        res_d.quat_z = lane[2];
      end
      BR_Z: begin
        res_d.quat_w = lane[0];
        res_d.quat_x = lane[1];
        res_d.quat_y = lane[2];
        res_d.quat_z = fp.prin;
      end
    endcase
    if (fp.side.dg) begin
      res_d = '0;
      res_d.degenerate = 1'b1;
    end
  end

  // output register
  logic     out_vld_q;
  lqa_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = out_vld_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lqa_checker.sv
`default_nettype none

module lqa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input lqa_pkg::lqa_in_t  in_i,
  input logic              valid_o,
  input lqa_pkg::lqa_out_t res_o
);
  import lqa_pkg::*;

  localparam int Latency = 209;

  // the pipeline takes a beat in every cycle
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // no result beat while in reset, once reset has been seen at an edge
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni ##1 !rst_ni |-> !valid_o)
    else $error("result beat during reset");

  // a degenerate result carries a zero quaternion
  a_dg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.degenerate |->
      res_o.quat_w == 0 && res_o.quat_x == 0 && res_o.quat_y == 0 && res_o.quat_z == 0)
    else $error("degenerate result with nonzero quaternion");

  // eye on the target comes out flagged; the beat is taken at the edge that ends its cycle
  a_same_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_i.eye_x == in_i.aim_x && in_i.eye_y == in_i.aim_y &&
      in_i.eye_z == in_i.aim_z |-> ##(Latency + 1) (valid_o && res_o.degenerate))
    else $error("eye on target not flagged degenerate");

endmodule

bind look_at_quaternion_unit lqa_checker u_lqa_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .in_i    (in_i),
  .valid_o (valid_o),
  .res_o   (res_o)
);

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import lqa_pkg::*;

  typedef longint vec3_t [3];

  localparam longint ONE_Q = 64'sd1 << QFB;
  localparam int PIPE_LAT = 209;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  lqa_in_t  in_i;
  logic     valid_o;
  lqa_out_t res_o;

  lqa_out_t quat_q[$];
  int       n_err;
  bit       gaps_on;

  look_at_quaternion_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // floor integer square root
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    res = '0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // half away from zero of num / den, den > 0
  function automatic longint div_half(input longint num, input longint den);
    logic [63:0] m;
    logic [63:0] d;
    longint q;
    m = mag(num);
    d = 64'(den);
    q = longint'((m + d / 2) / d);
    return num < 0 ? -q : q;
  endfunction

  function automatic longint qroot(input longint rad);
    if (rad < 0) rad = 0;
    return longint'(isqrt(64'(rad) << QFB));
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // scale to a unit vector in Q format; 0 for a zero vector
  function automatic bit to_unit(input vec3_t v, output vec3_t u);
    logic [63:0] m [3];
    logic [63:0] mx;
    logic [63:0] sum;
    logic [63:0] len;
    longint c;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      c = longint'(((m[i] << QFB) + len / 2) / len);
      u[i] = v[i] < 0 ? -c : c;
    end
    return 1'b1;
  endfunction

  // expected quaternion for one look-at beat
  function automatic lqa_out_t look_at_quat(input lqa_in_t b);
    vec3_t d, f, r0, r, nu;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22, tr, sq, s;
    longint q [4];
    lqa_out_t o;
    o = '0;
    d[0] = longint'(b.eye_x) - longint'(b.aim_x);
    d[1] = longint'(b.aim_y) - longint'(b.eye_y);
    d[2] = longint'(b.aim_z) - longint'(b.eye_z);
    if (!to_unit(d, f)) begin
      o.degenerate = 1'b1;
      return o;
    end
    r0[0] = f[2];
    r0[1] = 0;
    r0[2] = -f[0];
    if (!to_unit(r0, r)) begin
      o.degenerate = 1'b1;
      return o;
    end
    nu[0] = (f[1] * r[2] - f[2] * r[1] + (64'sd1 << (QFB - 1))) >>> QFB;
    nu[1] = (f[2] * r[0] - f[0] * r[2] + (64'sd1 << (QFB - 1))) >>> QFB;
    nu[2] = (f[0] * r[1] - f[1] * r[0] + (64'sd1 << (QFB - 1))) >>> QFB;
    m00 = r[0];  m01 = r[1];  m02 = r[2];
    m10 = nu[0]; m11 = nu[1]; m12 = nu[2];
    m20 = f[0];  m21 = f[1];  m22 = f[2];
    tr = m00 + m11 + m22;
    if (tr > 0) sq = qroot(tr + ONE_Q);
    else if (m00 > m11 && m00 > m22) sq = qroot(ONE_Q + m00 - m11 - m22);
    else if (m11 > m22) sq = qroot(ONE_Q + m11 - m00 - m22);
    else sq = qroot(ONE_Q + m22 - m00 - m11);
    s = 2 * sq;
    if (s == 0) s = 1;
    if (tr > 0) begin
      q[0] = (sq + 1) >>> 1;
      q[1] = div_half((m21 - m12) * ONE_Q, s);
      q[2] = div_half((m02 - m20) * ONE_Q, s);
      q[3] = div_half((m10 - m01) * ONE_Q, s);
    end else if (m00 > m11 && m00 > m22) begin
      q[0] = div_half((m21 - m12) * ONE_Q, s);
      q[1] = (sq + 1) >>> 1;
      q[2] = div_half((m01 + m10) * ONE_Q, s);
      q[3] = div_half((m02 + m20) * ONE_Q, s);
    end else if (m11 > m22) begin
      q[0] = div_half((m02 - m20) * ONE_Q, s);
      q[1] = div_half((m01 + m10) * ONE_Q, s);
      q[2] = (sq + 1) >>> 1;
      q[3] = div_half((m12 + m21) * ONE_Q, s);
    end else begin
      q[0] = div_half((m10 - m01) * ONE_Q, s);
      q[1] = div_half((m02 + m20) * ONE_Q, s);
      q[2] = div_half((m12 + m21) * ONE_Q, s);
      q[3] = (sq + 1) >>> 1;
    end
    o.quat_w = clip32(q[0]);
    o.quat_x = clip32(q[1]);
    o.quat_y = clip32(q[2]);
    o.quat_z = clip32(q[3]);
    return o;
  endfunction

  // send one beat; called right after a rising edge, returns right after one
  task automatic send_beat(input lqa_in_t b);
    bit ok;
    start <= 1'b1;
    in_i  <= b;
    do begin
      @(negedge clk_i);
      ok = !busy;
      @(posedge clk_i);
    end while (!ok);
    quat_q.push_back(look_at_quat(b));
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      in_i  <= lqa_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  function automatic lqa_in_t mk_beat(input int ex, ey, ez, ax, ay, az);
    lqa_in_t b;
    b.eye_x = ex; b.eye_y = ey; b.eye_z = ez;
    b.aim_x = ax; b.aim_y = ay; b.aim_z = az;
    return b;
  endfunction

  // result check
  always @(negedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (quat_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, res_o);
        n_err++;
      end else begin
        lqa_out_t e;
        e = quat_q.pop_front();
        if (res_o.quat_w !== e.quat_w || res_o.quat_x !== e.quat_x ||
            res_o.quat_y !== e.quat_y || res_o.quat_z !== e.quat_z ||
            res_o.degenerate !== e.degenerate) begin
          $display("%0t: mismatch exp w=%h x=%h y=%h z=%h dg=%b", $realtime,
                   e.quat_w, e.quat_x, e.quat_y, e.quat_z, e.degenerate);
          $display("%0t:          act w=%h x=%h y=%h z=%h dg=%b", $realtime,
                   res_o.quat_w, res_o.quat_x, res_o.quat_y, res_o.quat_z,
                   res_o.degenerate);
          n_err++;
        end
      end
    end
  end

  // extremes, degenerate cases and each conversion branch
  task automatic test_directed();
    int u;
    u = 32'sh10000;
    send_beat(mk_beat(0, 0, 0, 0, 0, 0));
    send_beat(mk_beat(5 * u, -3 * u, 7, 5 * u, -3 * u, 7));
    send_beat(mk_beat(0, 0, 0, 0, 4 * u, 0));
    send_beat(mk_beat(0, 0, 0, 0, -4 * u, 0));
    send_beat(mk_beat(0, 32'h7fffffff, 0, 0, 32'h80000000, 0));
    send_beat(mk_beat(0, 0, 0, 1, 32'h7fffffff, 0));
    send_beat(mk_beat(32'h7fffffff, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h7fffffff, 32'h7fffffff));
    send_beat(mk_beat(32'h80000000, 32'h7fffffff, 32'h7fffffff,
                      32'h7fffffff, 32'h80000000, 32'h80000000));
    send_beat(mk_beat(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0));
    send_beat(mk_beat(0, 0, 0, 0, 0, u));
    send_beat(mk_beat(0, 0, 0, 0, 0, -u));
    send_beat(mk_beat(u, 0, 0, 0, 0, 0));
    send_beat(mk_beat(-u, 0, 0, 0, 0, 0));
    send_beat(mk_beat(0, 0, 0, u, u, u));
    send_beat(mk_beat(0, 0, 0, -u, -u, -u));
    send_beat(mk_beat(0, 0, 0, u, -u, -u));
    send_beat(mk_beat(0, 0, 0, -u, u, -u));
    send_beat(mk_beat(0, 0, 0, 1, 0, -1));
    send_beat(mk_beat(0, 0, 0, -1, 0, 1));
    send_beat(mk_beat(0, 0, 0, 0, 1000 * u, 1));
    send_beat(mk_beat(3 * u, 0, 0, 0, 0, 0));
  endtask

  // random look-at beats of several kinds
  task automatic test_random(input int n);
    lqa_in_t b;
    for (int i = 0; i < n; i++) begin
      if (i > n - n / 6) gaps_on = 1'b0;
      b = lqa_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        3, 4: begin
          b.aim_x = b.eye_x + $signed($urandom_range(0, 8191)) - 4096;
          b.aim_y = b.eye_y + $signed($urandom_range(0, 8191)) - 4096;
          b.aim_z = b.eye_z + $signed($urandom_range(0, 8191)) - 4096;
        end
        5: begin
          b.aim_x = b.eye_x;
          b.aim_z = b.eye_z;
          if ($urandom_range(0, 1)) b.aim_y = b.eye_y;
        end
        6: begin
          b.aim_x = b.eye_x + $signed($urandom_range(0, 2)) - 1;
          b.aim_z = b.eye_z + $signed($urandom_range(0, 2)) - 1;
        end
        7: begin
          b.eye_x = $signed($urandom) >>> $urandom_range(0, 31);
          b.eye_z = $signed($urandom) >>> $urandom_range(0, 31);
          b.aim_y = b.eye_y + ($signed($urandom) >>> $urandom_range(0, 31));
          b.aim_x = 0;
          b.aim_z = 0;
        end
        default: begin
          b.eye_x = $signed($urandom) >>> 8;
          b.eye_y = $signed($urandom) >>> 8;
          b.eye_z = $signed($urandom) >>> 8;
          b.aim_x = $signed($urandom) >>> 8;
          b.aim_y = $signed($urandom) >>> 8;
          b.aim_z = $signed($urandom) >>> 8;
        end
      endcase
      send_beat(b);
    end
  endtask

  // main sequence
  initial begin
    n_err   = 0;
    gaps_on = 1'b1;
    rst_ni  = 1'b0;
    start   = 1'b0;
    in_i    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1180);
    start <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 20) @(posedge clk_i);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lqa_pkg.sv
hw/rtl/lqa_sqrt_cell.sv
hw/rtl/lqa_div_cell.sv
hw/rtl/lqa_norm.sv
hw/rtl/look_at_quaternion_unit.sv
hw/rtl/lqa_checker.sv
test/tb_top.sv
